// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks; they compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Checks that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ----- src/rbbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rbbs_pkg
// Types and constants shared by the raster beam and bad-line sequencer.
// ----------------------------------------------------------------------------
package rbbs_pkg;

   localparam int LINE_W  = 9;
   localparam int CYC_W   = 7;
   localparam int ROW_W   = 3;
   localparam int VC_W    = 10;
   localparam int PF_W    = 4;
   localparam int YS_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam int FIRST_DMA_LINE_DEF = 48;
   localparam int LAST_DMA_LINE_DEF  = 247;

   // Beam cycle landmarks.
   localparam logic [CYC_W-1:0] CYC_SKIP_FROM  = 7'd54;
   localparam logic [CYC_W-1:0] CYC_SKIP_TO    = 7'd56;
   localparam logic [CYC_W-1:0] CYC_SHORT_LINE = 7'd63;
   localparam logic [CYC_W-1:0] CYC_LINE_STEP  = 7'd64;
   localparam logic [CYC_W-1:0] CYC_WRAP       = 7'd65;
   localparam logic [CYC_W-1:0] CYC_VBLANK     = 7'd10;
   localparam logic [CYC_W-1:0] CYC_LOAD_VC    = 7'd13;
   localparam logic [CYC_W-1:0] CYC_WIN_FIRST  = 7'd14;
   localparam logic [CYC_W-1:0] CYC_WIN_LAST   = 7'd53;
   localparam logic [CYC_W-1:0] CYC_ROW_STEP   = 7'd58;
   localparam logic [ROW_W-1:0] ROW_LAST       = 3'd7;

   localparam logic [LINE_W-1:0] RST_FRAME_LINES = 9'd312;
   localparam logic [CYC_W-1:0]  RST_CYCLES_LINE = 7'd63;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_LINES     = 3'd0,
      CSR_LINE_CYCLES     = 3'd1,
      CSR_IRQ_LINE        = 3'd2,
      CSR_IRQ_CYCLE       = 3'd3,
      CSR_COLOR_FETCH_OFF = 3'd4,
      CSR_BLIT_ON_VBLANK  = 3'd5,
      CSR_DMA_ON_VBLANK   = 3'd6,
      CSR_LINEAR_MODE     = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [LINE_W-1:0] frame_lines;
      logic [CYC_W-1:0]  line_cycles;
      logic [LINE_W-1:0] irq_line;
      logic [CYC_W-1:0]  irq_cycle;
      logic              color_fetch_off;
      logic              blit_on_vblank;
      logic              dma_on_vblank;
      logic              linear_mode;
   } cfg_type;

   typedef struct packed {
      logic [YS_W-1:0] ysmooth;
      logic            display_enable;
      logic            matrix_ba;
      logic            sprite_ba;
      logic            prefetch_load;
      logic [PF_W-1:0] prefetch_value;
   } req_payload_type;

   typedef struct packed {
      logic [LINE_W-1:0] line_now;
      logic [CYC_W-1:0]  cycle_now;
      logic              is_bad_line;
      logic              in_display;
      logic [ROW_W-1:0]  row_count;
      logic [VC_W-1:0]   video_count;
      logic              raster_irq;
      logic              blit_start;
      logic              dma_start;
      logic              bus_low;
      logic              graphics_fetch;
      logic              linear_fetch;
   } rsp_payload_type;

   // Beam position after a step, plus the events the beam raised.
   typedef struct packed {
      logic [LINE_W-1:0] line;
      logic [LINE_W-1:0] prev_line;
      logic [CYC_W-1:0]  cycle;
      logic              line_end;
      logic              raster_irq;
      logic              blit_start;
      logic              dma_start;
   } beam_evt_type;

endpackage

// ----- src/rbbs_beam.sv -----
// ----------------------------------------------------------------------------
// rbbs_beam
// Beam cycle and raster line counters with interrupt and vblank events.
// ----------------------------------------------------------------------------
module rbbs_beam (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  rbbs_pkg::cfg_type     cfg,
   output rbbs_pkg::beam_evt_type evt
);
   import rbbs_pkg::*;

   logic [CYC_W-1:0]  beam_cycle_ff, beam_cycle_in;
   logic [LINE_W-1:0] beam_line_ff,  beam_line_in;

   always_comb begin
      beam_cycle_in = beam_cycle_ff + CYC_W'(1);
      beam_line_in  = beam_line_ff;
      evt.line_end  = 1'b0;
      if (beam_cycle_in == CYC_SKIP_FROM && cfg.line_cycles == CYC_SHORT_LINE) begin
         beam_cycle_in = CYC_SKIP_TO;
      end
      if (beam_cycle_in == CYC_WRAP) begin
         beam_cycle_in = '0;
         evt.line_end  = 1'b1;
      end
      if (beam_cycle_in == CYC_LINE_STEP) begin
         beam_line_in = beam_line_ff + LINE_W'(1);
         if (beam_line_in == cfg.frame_lines) begin
            beam_line_in = '0;
         end
      end
      evt.line       = beam_line_in;
      evt.prev_line  = beam_line_ff;
      evt.cycle      = beam_cycle_in;
      evt.raster_irq = (beam_line_in == cfg.irq_line) && (beam_cycle_in == cfg.irq_cycle);
      evt.blit_start = 1'b0;
      evt.dma_start  = 1'b0;
      if ((cfg.frame_lines != '0) && (beam_line_in == cfg.frame_lines - LINE_W'(1))
          && (beam_cycle_in == CYC_VBLANK)) begin
         evt.blit_start = cfg.blit_on_vblank;
         evt.dma_start  = cfg.dma_on_vblank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_cycle_ff <= '0;
         beam_line_ff  <= '0;
      end else if (step_en) begin
         beam_cycle_ff <= beam_cycle_in;
         beam_line_ff  <= beam_line_in;
      end
   end

endmodule

// ----- src/rbbs_video.sv -----
// ----------------------------------------------------------------------------
// rbbs_video
// Bad-line detection, display state, row and video counters, bus request.
// ----------------------------------------------------------------------------
module rbbs_video #(
   parameter int FIRST_DMA_LINE = rbbs_pkg::FIRST_DMA_LINE_DEF,
   parameter int LAST_DMA_LINE  = rbbs_pkg::LAST_DMA_LINE_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  rbbs_pkg::cfg_type        cfg,
   input  rbbs_pkg::beam_evt_type   evt,
   input  rbbs_pkg::req_payload_type req,
   output rbbs_pkg::rsp_payload_type rsp
);
   import rbbs_pkg::*;

   localparam logic [LINE_W-1:0] FIRST_LINE = LINE_W'(FIRST_DMA_LINE);
   localparam logic [LINE_W-1:0] LAST_LINE  = LINE_W'(LAST_DMA_LINE);

   logic             allowed_ff, allowed_in;
   logic             bad_ff,     bad_in;
   logic             idle_ff,    idle_in;
   logic [ROW_W-1:0] row_ff,     row_in;
   logic [VC_W-1:0]  vc_ff,      vc_in;
   logic [VC_W-1:0]  vbase_ff,   vbase_in;
   logic [PF_W-1:0]  pf_ff,      pf_in;
   logic             window;
   logic             bus_req;

   always_comb begin
      allowed_in = allowed_ff;
      bad_in     = bad_ff;
      idle_in    = idle_ff;
      row_in     = row_ff;
      vc_in      = vc_ff;
      vbase_in   = vbase_ff;
      pf_in      = req.prefetch_load ? req.prefetch_value : pf_ff;

      if (evt.line_end) begin
         if (evt.prev_line == FIRST_LINE && !allowed_in && req.display_enable) begin
            allowed_in = 1'b1;
         end
         if (evt.prev_line == LAST_LINE) begin
            allowed_in = 1'b0;
         end
         bad_in = 1'b0;
      end

      if (evt.line == FIRST_LINE && !allowed_in) begin
         allowed_in = req.display_enable;
      end

      if (allowed_in) begin
         if (evt.line[YS_W-1:0] == req.ysmooth) begin
            bad_in  = 1'b1;
            idle_in = 1'b0;
         end else begin
            bad_in = 1'b0;
         end
      end

      if (evt.cycle == CYC_LOAD_VC) begin
         vc_in = vbase_in;
         if (bad_in) begin
            row_in = '0;
         end
      end

      if (evt.cycle == CYC_ROW_STEP) begin
         if (row_in == ROW_LAST) begin
            idle_in  = 1'b1;
            vbase_in = vc_in;
         end
         if (!idle_in || bad_in) begin
            row_in  = row_in + ROW_W'(1);
            idle_in = 1'b0;
         end
      end

      window  = (evt.cycle >= CYC_WIN_FIRST) && (evt.cycle <= CYC_WIN_LAST);
      bus_req = (pf_in != '0) && !cfg.color_fetch_off;
      if (window && bad_in) begin
         bus_req = bus_req | req.matrix_ba;
      end
      bus_req = bus_req | req.sprite_ba;

      if (pf_in != '0) begin
         pf_in = pf_in - PF_W'(1);
      end

      // A graphics fetch steps the video counter once.
      if (!idle_in && window) begin
         vc_in = vc_in + VC_W'(1);
      end

      rsp.line_now       = evt.line;
      rsp.cycle_now      = evt.cycle;
      rsp.is_bad_line    = bad_in;
      rsp.in_display     = !idle_in;
      rsp.row_count      = row_in;
      rsp.video_count    = vc_in;
      rsp.raster_irq     = evt.raster_irq;
      rsp.blit_start     = evt.blit_start;
      rsp.dma_start      = evt.dma_start;
      rsp.bus_low        = bus_req;
      rsp.graphics_fetch = !idle_in && window;
      rsp.linear_fetch   = window && cfg.linear_mode;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allowed_ff <= 1'b0;
         bad_ff     <= 1'b0;
         idle_ff    <= 1'b1;
         row_ff     <= '0;
         vc_ff      <= '0;
         vbase_ff   <= '0;
         pf_ff      <= '0;
      end else if (step_en) begin
         allowed_ff <= allowed_in;
         bad_ff     <= bad_in;
         idle_ff    <= idle_in;
         row_ff     <= row_in;
         vc_ff      <= vc_in;
         vbase_ff   <= vbase_in;
         pf_ff      <= pf_in;
      end
   end

endmodule

// ----- src/raster_beam_badline_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// raster_beam_badline_sequencer_unit
// Video beam timing, bad-line sequencing and bus request generation.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel stands for one video-chip cycle. It
// carries the vertical scroll, the display-enable bit, the bus requests of
// the matrix and sprite fetch units and an optional prefetch counter load.
// For every request transfer the block delivers exactly one rsp_ transfer
// with the beam position after that cycle, the bad-line and display state,
// the row and video counters and the event strobes (raster interrupt,
// vblank blitter and DMA starts, bus low, graphics and linear fetch).
// A request accepted at a clock edge shows up as a valid response in the
// cycle after it. The whole step is one pass of logic between the
// beam/video state and the response register, so throughput is one
// transfer per clock while the receiver takes responses. When the
// receiver stalls, the response register holds its transfer and req_ready
// drops; a new request is taken in the same cycle the held response
// leaves. Synchronous reset puts the beam at line 0, cycle 0, idle state,
// and loads the register defaults (312 frame lines, line length RST_CYCLES_LINE); req_ready is low
// while reset is asserted. The csr_ port writes one register per cycle and
// should be used while no transfer is in flight.
module raster_beam_badline_sequencer_unit #(
   parameter int FIRST_DMA_LINE = rbbs_pkg::FIRST_DMA_LINE_DEF,
   parameter int LAST_DMA_LINE  = rbbs_pkg::LAST_DMA_LINE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rbbs_pkg::req_payload_type           req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rbbs_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_we,
   input  logic [rbbs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rbbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rbbs_pkg::*;

`include "assert_macros.svh"

   cfg_type         cfg_ff;
   beam_evt_type    beam_evt;
   rsp_payload_type rsp_in;
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff;
   logic            step_en;

   // A request transfer completes whenever the response register is empty
   // or its contents leave in this same cycle.
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign step_en   = req_valid && req_ready;

   // Configuration registers: one write per enabled edge.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_lines     <= RST_FRAME_LINES;
         cfg_ff.line_cycles     <= RST_CYCLES_LINE;
         cfg_ff.irq_line        <= '0;
         cfg_ff.irq_cycle       <= '0;
         cfg_ff.color_fetch_off <= 1'b0;
         cfg_ff.blit_on_vblank  <= 1'b0;
         cfg_ff.dma_on_vblank   <= 1'b0;
         cfg_ff.linear_mode     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FRAME_LINES:     cfg_ff.frame_lines     <= csr_wdata[LINE_W-1:0];
            CSR_LINE_CYCLES:     cfg_ff.line_cycles     <= csr_wdata[CYC_W-1:0];
            CSR_IRQ_LINE:        cfg_ff.irq_line        <= csr_wdata[LINE_W-1:0];
            CSR_IRQ_CYCLE:       cfg_ff.irq_cycle       <= csr_wdata[CYC_W-1:0];
            CSR_COLOR_FETCH_OFF: cfg_ff.color_fetch_off <= csr_wdata[0];
            CSR_BLIT_ON_VBLANK:  cfg_ff.blit_on_vblank  <= csr_wdata[0];
            CSR_DMA_ON_VBLANK:   cfg_ff.dma_on_vblank   <= csr_wdata[0];
            CSR_LINEAR_MODE:     cfg_ff.linear_mode     <= csr_wdata[0];
         endcase
      end
   end

   // Beam position, raster interrupt and vblank starts.
   rbbs_beam u_beam (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .cfg     (cfg_ff),
      .evt     (beam_evt)
   );

   // Bad lines, display state, counters and the bus request.
   rbbs_video #(
      .FIRST_DMA_LINE (FIRST_DMA_LINE),
      .LAST_DMA_LINE  (LAST_DMA_LINE)
   ) u_video (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .cfg     (cfg_ff),
      .evt     (beam_evt),
      .req     (req_data),
      .rsp     (rsp_in)
   );

   // Response register. The payload needs no reset; the valid flag does.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Every accepted request yields a response on the next cycle.
   `ASSERT_PROP(a_req_gives_rsp, clock, reset, step_en |=> rsp_valid)
   // Requests are refused only while a response is held by a stalled receiver.
   `ASSERT_PROP(a_stall_only, clock, reset, !req_ready |-> (rsp_valid && !rsp_ready))
   // The beam cycle wraps before it can reach the wrap value.
   `ASSERT_NEVER(a_cycle_range, clock, reset, rsp_valid && (rsp_data.cycle_now > CYC_LINE_STEP))
   // Graphics fetches only happen in display state.
   `ASSERT_PROP(a_fetch_display, clock, reset,
                (rsp_valid && rsp_data.graphics_fetch) |-> rsp_data.in_display)

endmodule
